### rtl/pwrw_pkg.sv
package pwrw_pkg;

    // field and register widths
    localparam int CMD_W      = 2;
    localparam int TIME_BITS  = 48;
    localparam int ACK_W      = 16;
    localparam int WIN_W      = 32;
    localparam int SEG_W      = 16;
    localparam int PER_W      = 40;
    localparam int TOT_W      = 40;
    localparam int GAIN_W     = 16;
    localparam int PROG_W     = 17;
    localparam int BYTES_W    = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    // restart window in segments
    localparam int RESTART_SEGS = 10;

    // shared divider: 64-bit dividend, divisor up to cwnd segments << 12
    localparam int DIVD_W = 64;
    localparam int DIVS_W = 44;
    localparam int CNT_W  = $clog2(DIVD_W);
    // increment quotient: 48-bit numerator over a divisor of at least 4096
    localparam int INC_W  = 36;

    localparam logic [PROG_W-1:0] ONE_Q16 = PROG_W'(65536);

    // input command codes
    localparam logic [CMD_W-1:0] CMD_ACK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INC  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOSS = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 3'd4;

    // register reset values
    localparam logic [SEG_W-1:0]  RST_SEGMENT = SEG_W'(1448);
    localparam logic [PER_W-1:0]  RST_PERIOD  = PER_W'(1000000000);
    localparam logic [TOT_W-1:0]  RST_TOTAL   = TOT_W'(250000000);
    localparam logic [GAIN_W-1:0] RST_SLOPE   = GAIN_W'(16384);
    localparam logic [GAIN_W-1:0] RST_OFFSET  = GAIN_W'(1024);

    typedef enum logic [1:0] {
        DSEL_PROG,
        DSEL_W,
        DSEL_INC
    } t_div_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_DPROG,
        S_WPROG,
        S_GAIN,
        S_MUL2,
        S_DW,
        S_WW,
        S_DI,
        S_WI,
        S_FIN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic     load;
        logic     mul1;
        logic     acc;
        logic     gain;
        logic     mul2;
        logic     div_start;
        t_div_sel div_sel;
        logic     prog_load;
        logic     w_load;
        logic     inc_load;
        logic     fin;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd_code;
        logic             late;
        logic             total_zero;
        logic             slow_start;
        logic             div_done;
        logic             out_free;
    } t_dp_stat;

endpackage

### rtl/pwrw_div.sv
module pwrw_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pwrw_pkg::DIVD_W-1:0]  i_dividend,
    input  logic [pwrw_pkg::DIVS_W-1:0]  i_divisor,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [pwrw_pkg::DIVD_W-1:0]  o_quotient
);
    import pwrw_pkg::*;

    logic              r_busy, r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_dvs;

    logic [DIVS_W:0]   rem_sh;
    logic [DIVS_W+1:0] diff;
    logic              ge;

    // one restoring step: shift in next dividend bit, try subtract
    always_comb begin
        rem_sh = {r_rem, r_quo[DIVD_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_dvs};
        ge     = ~diff[DIVS_W+1];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVD_W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // data
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVD_W-2:0], ge};
            r_rem <= ge ? diff[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### rtl/pwrw_dp.sv
module pwrw_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_wr_en,
    input  logic [pwrw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pwrw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input word fields
    input  logic [pwrw_pkg::CMD_W-1:0]       i_command,
    input  logic [pwrw_pkg::TIME_BITS-1:0]   i_now_time,
    input  logic [pwrw_pkg::ACK_W-1:0]       i_segments_acked,
    input  logic [pwrw_pkg::WIN_W-1:0]       i_cwnd_in,
    input  logic [pwrw_pkg::WIN_W-1:0]       i_ssthresh_in,
    // control
    input  pwrw_pkg::t_dp_cmd                i_cmd,
    output pwrw_pkg::t_dp_stat               o_stat,
    // result word
    input  logic                             i_m_tready,
    output logic                             o_m_tvalid,
    output logic [pwrw_pkg::WIN_W-1:0]       o_cwnd_out,
    output logic [pwrw_pkg::WIN_W-1:0]       o_ssthresh_out,
    output logic                             o_window_reset,
    output logic [pwrw_pkg::PROG_W-1:0]      o_progress_out
);
    import pwrw_pkg::*;

    // configuration registers
    logic [SEG_W-1:0]  r_seg;
    logic [PER_W-1:0]  r_period;
    logic [TOT_W-1:0]  r_total;
    logic [GAIN_W-1:0] r_slope;
    logic [GAIN_W-1:0] r_offset;

    // flow state
    logic [BYTES_W-1:0]   r_bytes;
    logic [TIME_BITS-1:0] r_last;
    logic [PROG_W-1:0]    r_progress;
    logic                 r_restart;
    logic                 r_out_valid;

    // captured word and intermediates
    logic [CMD_W-1:0]     r_cmd;
    logic [TIME_BITS-1:0] r_now;
    logic [ACK_W-1:0]     r_acked;
    logic [WIN_W-1:0]     r_cwnd;
    logic [WIN_W-1:0]     r_ssth;
    logic [WIN_W-1:0]     r_as;
    logic [GAIN_W+PROG_W-1:0] r_sprod;
    logic                 r_late;
    logic [GAIN_W-1:0]    r_gain;
    logic [WIN_W+GAIN_W-1:0] r_num;
    logic [WIN_W-1:0]     r_w;
    logic [INC_W-1:0]     r_inc;

    // output register
    logic [WIN_W-1:0]  r_o_cwnd;
    logic [WIN_W-1:0]  r_o_ssth;
    logic              r_o_reset;
    logic [PROG_W-1:0] r_o_prog;

    // divider
    logic [DIVD_W-1:0] div_dividend;
    logic [DIVS_W-1:0] div_divisor;
    logic              div_busy, div_done;
    logic [DIVD_W-1:0] div_q;

    pwrw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // divider operand select
    always_comb begin
        unique case (i_cmd.div_sel)
            DSEL_PROG: begin
                div_dividend = {r_bytes, 16'd0};
                div_divisor  = DIVS_W'(r_total);
            end
            DSEL_W: begin
                div_dividend = DIVD_W'(r_cwnd);
                div_divisor  = DIVS_W'(r_seg);
            end
            DSEL_INC: begin
                div_dividend = DIVD_W'(r_num);
                div_divisor  = {r_w, 12'd0};
            end
            default: begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    // phase restart test: elapsed > floor(0.9*period)  <=>  10*elapsed > 9*period
    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS+3:0] ten_e;
    logic [PER_W+3:0]     nine_p;
    always_comb begin
        elapsed = r_now - r_last;
        ten_e   = ({4'd0, elapsed} << 3) + ({4'd0, elapsed} << 1);
        nine_p  = ({4'd0, r_period} << 3) + {4'd0, r_period};
    end

    // saturating byte total
    logic [BYTES_W:0] bytes_sum;
    assign bytes_sum = {1'b0, r_bytes} + (BYTES_W+1)'(r_as);

    // gain = slope*progress/65536 + offset, saturating
    logic [GAIN_W+1:0] gain_sum;
    assign gain_sum = (GAIN_W+2)'(r_sprod[GAIN_W+PROG_W-1:16]) + (GAIN_W+2)'(r_offset);

    // result assembly
    logic [WIN_W:0]       ss_sum;
    logic [INC_W:0]       ca_sum;
    logic [WIN_W-2:0]     half;
    logic [SEG_W:0]       floor2;
    logic [WIN_W-1:0]     n_o_cwnd;
    logic [WIN_W-1:0]     n_o_ssth;
    always_comb begin
        ss_sum   = {1'b0, r_cwnd} + {1'b0, r_as};
        ca_sum   = (INC_W+1)'(r_cwnd) + {1'b0, r_inc};
        half     = r_cwnd[WIN_W-1:1];
        floor2   = {r_seg, 1'b0};
        n_o_cwnd = r_cwnd;
        n_o_ssth = r_ssth;
        unique case (r_cmd)
            CMD_ACK: begin
                if (r_restart)
                    n_o_cwnd = WIN_W'(r_seg) * WIN_W'(RESTART_SEGS);
            end
            CMD_INC: begin
                if (r_cwnd < r_ssth)
                    n_o_cwnd = (ss_sum < {1'b0, r_ssth}) ? ss_sum[WIN_W-1:0] : r_ssth;
                else if (ca_sum[INC_W:WIN_W] != '0)
                    n_o_cwnd = '1;
                else
                    n_o_cwnd = ca_sum[WIN_W-1:0];
            end
            CMD_LOSS: begin
                n_o_ssth = (WIN_W'(half) > WIN_W'(floor2)) ? WIN_W'(half) : WIN_W'(floor2);
            end
            default: ;
        endcase
    end

    // configuration writes and flow state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg       <= RST_SEGMENT;
            r_period    <= RST_PERIOD;
            r_total     <= RST_TOTAL;
            r_slope     <= RST_SLOPE;
            r_offset    <= RST_OFFSET;
            r_bytes     <= '0;
            r_last      <= '0;
            r_progress  <= '0;
            r_restart   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_SEGMENT: r_seg    <= i_cfg_data[SEG_W-1:0];
                    CFG_PERIOD:  r_period <= i_cfg_data[PER_W-1:0];
                    CFG_TOTAL:   r_total  <= i_cfg_data[TOT_W-1:0];
                    CFG_SLOPE:   r_slope  <= i_cfg_data[GAIN_W-1:0];
                    CFG_OFFSET:  r_offset <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load)
                r_restart <= 1'b0;
            if (i_cmd.acc) begin
                r_last <= r_now;
                if (r_late) begin
                    r_bytes    <= '0;
                    r_progress <= '0;
                    r_restart  <= 1'b1;
                end else begin
                    r_bytes <= bytes_sum[BYTES_W] ? '1 : bytes_sum[BYTES_W-1:0];
                    if (r_total == '0)
                        r_progress <= ONE_Q16;
                end
            end
            if (i_cmd.prog_load)
                r_progress <= (div_q > DIVD_W'(ONE_Q16)) ? ONE_Q16 : div_q[PROG_W-1:0];
            // output stage
            if (i_cmd.fin)
                r_out_valid <= 1'b1;
            else if (i_m_tready)
                r_out_valid <= 1'b0;
        end
    end

    // word capture and arithmetic steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_command;
            r_now   <= i_now_time;
            r_acked <= i_segments_acked;
            r_cwnd  <= i_cwnd_in;
            r_ssth  <= i_ssthresh_in;
        end
        if (i_cmd.mul1) begin
            r_as    <= WIN_W'(r_acked) * WIN_W'(r_seg);
            r_sprod <= (GAIN_W+PROG_W)'(r_slope) * (GAIN_W+PROG_W)'(r_progress);
            r_late  <= ((TIME_BITS+4)'(nine_p) < ten_e);
        end
        if (i_cmd.gain)
            r_gain <= gain_sum[GAIN_W+1:GAIN_W] != 2'b00 ? '1 : gain_sum[GAIN_W-1:0];
        if (i_cmd.mul2)
            r_num <= (WIN_W+GAIN_W)'(r_as) * (WIN_W+GAIN_W)'(r_gain);
        if (i_cmd.w_load)
            r_w <= (r_seg == '0 || div_q[WIN_W-1:0] == '0) ? WIN_W'(1) : div_q[WIN_W-1:0];
        if (i_cmd.inc_load)
            r_inc <= div_q[INC_W-1:0];
        if (i_cmd.fin) begin
            r_o_cwnd  <= n_o_cwnd;
            r_o_ssth  <= n_o_ssth;
            r_o_reset <= (r_cmd == CMD_ACK) && r_restart;
            r_o_prog  <= r_progress;
        end
    end

    // status
    always_comb begin
        o_stat.cmd_code   = r_cmd;
        o_stat.late       = r_late;
        o_stat.total_zero = (r_total == '0);
        o_stat.slow_start = (r_cwnd < r_ssth);
        o_stat.div_done   = div_done;
        o_stat.out_free   = !r_out_valid || i_m_tready;
    end

    assign o_m_tvalid     = r_out_valid;
    assign o_cwnd_out     = r_o_cwnd;
    assign o_ssthresh_out = r_o_ssth;
    assign o_window_reset = r_o_reset;
    assign o_progress_out = r_o_prog;

    // progress never exceeds one
    a_prog_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_progress <= ONE_Q16)
        else $error("progress above one");

    // a finished word never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |-> (!r_out_valid || i_m_tready))
        else $error("result overwritten");

    // divider is only started when idle
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !div_busy)
        else $error("divider restarted while busy");

    // a phase restart leaves the byte total cleared
    a_restart_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.acc && r_late) |=> (r_bytes == '0 && r_progress == '0))
        else $error("restart did not clear totals");

endmodule

### rtl/pwrw_ctrl.sv
module pwrw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  pwrw_pkg::t_dp_stat i_stat,
    output pwrw_pkg::t_dp_cmd  o_cmd
);
    import pwrw_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        o_cmd.div_sel = DSEL_PROG;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul1 = 1'b1;
                if (i_stat.cmd_code == CMD_ACK)
                    n_state = S_ACC;
                else if (i_stat.cmd_code == CMD_INC && !i_stat.slow_start)
                    n_state = S_GAIN;
                else
                    n_state = S_FIN;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = (i_stat.late || i_stat.total_zero) ? S_FIN : S_DPROG;
            end
            S_DPROG: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DSEL_PROG;
                n_state         = S_WPROG;
            end
            S_WPROG: begin
                o_cmd.div_sel = DSEL_PROG;
                if (i_stat.div_done) begin
                    o_cmd.prog_load = 1'b1;
                    n_state         = S_FIN;
                end
            end
            S_GAIN: begin
                o_cmd.gain = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_DW;
            end
            S_DW: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DSEL_W;
                n_state         = S_WW;
            end
            S_WW: begin
                o_cmd.div_sel = DSEL_W;
                if (i_stat.div_done) begin
                    o_cmd.w_load = 1'b1;
                    n_state      = S_DI;
                end
            end
            S_DI: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DSEL_INC;
                n_state         = S_WI;
            end
            S_WI: begin
                o_cmd.div_sel = DSEL_INC;
                if (i_stat.div_done) begin
                    o_cmd.inc_load = 1'b1;
                    n_state        = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### rtl/progress_weighted_reno_window.sv
// Reno-style congestion window controller with a progress-weighted gain.
// Input stream (s_axis): one word per command; tuser carries the command
// (ack accounting, window increase, loss threshold), tdata the operands.
// Output stream (m_axis): exactly one result word per input word, in order.
// Configuration: i_cfg_wr_en writes i_cfg_data to register i_cfg_index
// (0 segment size, 1 compute period, 2 phase bytes, 3 gain slope,
// 4 gain offset); write only while no word is in flight.
// Loss, slow start and the unused code use no divide, nor does ack accounting
// that restarts the phase or sees zero phase bytes; ack accounting that
// updates progress runs one 64-step divide and congestion avoidance two.
// The next word is taken in the cycle after the result is issued.
// One word is in flight at a time; the shared 64-step restoring divider
// sets the rate. Output words sit in a register, so a new input is taken
// while the previous result waits; a result that finishes while the output
// register is still held by a stalled receiver waits in the controller.
// Synchronous active-low reset restores register defaults, clears the byte
// total, last ack time and progress, and empties the output register.
module progress_weighted_reno_window (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration
    input  logic                             i_cfg_wr_en,
    input  logic [pwrw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pwrw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [47:0] now_time, [63:48] segments_acked, [95:64] cwnd_in, [127:96] ssthresh_in
    input  logic [127:0] i_s_axis_tdata,
    // [1:0] command
    input  logic [pwrw_pkg::CMD_W-1:0]       i_s_axis_tuser,
    // output stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [31:0] cwnd_out, [63:32] ssthresh_out, [64] window_reset,
    // [81:65] progress_out, [87:82] zero
    output logic [87:0]  o_m_axis_tdata
);
    import pwrw_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    logic [WIN_W-1:0]  cwnd_out;
    logic [WIN_W-1:0]  ssth_out;
    logic              window_reset;
    logic [PROG_W-1:0] progress_out;

    pwrw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    pwrw_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_command        (i_s_axis_tuser),
        .i_now_time       (i_s_axis_tdata[47:0]),
        .i_segments_acked (i_s_axis_tdata[63:48]),
        .i_cwnd_in        (i_s_axis_tdata[95:64]),
        .i_ssthresh_in    (i_s_axis_tdata[127:96]),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_m_tready       (i_m_axis_tready),
        .o_m_tvalid       (o_m_axis_tvalid),
        .o_cwnd_out       (cwnd_out),
        .o_ssthresh_out   (ssth_out),
        .o_window_reset   (window_reset),
        .o_progress_out   (progress_out)
    );

    // pack result word, pad to whole bytes
    assign o_m_axis_tdata = {6'd0, progress_out, window_reset, ssth_out, cwnd_out};

endmodule
